[hdl/c3ss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3ss_pkg
// Shared types and constants of the 3x3 convolution SAD scorer.
// ----------------------------------------------------------------------------
package c3ss_pkg;

    localparam int MAX_IMAGE_SIZE_DEF = 1024;
    localparam int COEF_FRAC_BITS_DEF = 8;

    localparam int PIX_W    = 8;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = PIX_W + 1 + COEF_W;   // 25
    localparam int PSUM_W   = PROD_W + 2;           // one column of three taps
    localparam int SUM_W    = PSUM_W + 2;           // three columns
    localparam int SIZE_W   = 11;
    localparam int KROW_W   = 48;
    localparam int SCORE_W  = 28;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 28'hFFFFFFF;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_TOP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_MID   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_BOT   = 2'd3;

    // one window column, index 0 is the upper row
    typedef logic [2:0][PIX_W-1:0]  pix_col_t;
    typedef logic [2:0][COEF_W-1:0] coef_col_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic mask_top;
        logic mask_col;
    } cell_ctrl_t;

endpackage : c3ss_pkg
`default_nettype wire

[hdl/conv3x3_sad_scorer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_sad_scorer
// Filters a square source image with a 3x3 Q7.8 kernel and scores it against
// a target image by the sum of absolute differences.
// ----------------------------------------------------------------------------
// Usage: source/target pixel pairs enter in raster order on the s_ channel
// (valid/ready), s_last_pixel marks the final pair. One score word leaves on
// the m_ channel per image. Kernel rows and image size are written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Each pair goes through line store read, window shift and housekeeping,
// plus a multiply / sum / accumulate pass for an output pixel inside the row
// and a zero-column shift and one more pass for the one at the right edge;
// the next pair is taken only back in the idle state. Every window goes
// through the shared sum / clamp / accumulate path. After the last pair the
// rest of the row is padded with zero pairs and the final row is flushed from
// the line store, N more steps of the same kind, then the score is registered
// on m_ in the emit state. These steps skip the idle state and go straight
// back to the line store read.
// The score sits in an output register; a stalled receiver only holds the
// block once the next score is ready to leave.
// Reset clears control state, counters, window and score; config returns to
// N = 3 with 1.0 on the middle row's left tap. Line stores are not cleared.
// ----------------------------------------------------------------------------
module conv3x3_sad_scorer #(
    parameter int MAX_IMAGE_SIZE = c3ss_pkg::MAX_IMAGE_SIZE_DEF,
    parameter int COEF_FRAC_BITS = c3ss_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  wire [c3ss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [c3ss_pkg::KROW_W-1:0]        cfg_data,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire [c3ss_pkg::PIX_W-1:0]         s_source_pixel,
    input  wire [c3ss_pkg::PIX_W-1:0]         s_target_pixel,
    input  wire                               s_last_pixel,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [c3ss_pkg::SCORE_W-1:0]      m_image_score
);
    import c3ss_pkg::*;

    localparam int COL_W  = $clog2(MAX_IMAGE_SIZE);
    localparam int SZ_W   = ($clog2(MAX_IMAGE_SIZE + 1) > SIZE_W) ?
                            $clog2(MAX_IMAGE_SIZE + 1) : SIZE_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_READ   = 9'b000000010,
        S_SHIFT  = 9'b000000100,
        S_SHIFTB = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_SUM    = 9'b000100000,
        S_ACC    = 9'b001000000,
        S_NEXT   = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    // configuration
    logic [SIZE_W-1:0] size_reg;
    logic [KROW_W-1:0] krow_top_reg, krow_mid_reg, krow_bot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= SIZE_W'(3);
            krow_top_reg <= '0;
            krow_mid_reg <= KROW_W'(256);
            krow_bot_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_SIZE: size_reg     <= cfg_data[SIZE_W-1:0];
                CFG_KROW_TOP:   krow_top_reg <= cfg_data;
                CFG_KROW_MID:   krow_mid_reg <= cfg_data;
                CFG_KROW_BOT:   krow_bot_reg <= cfg_data;
                default:        size_reg     <= size_reg;
            endcase
        end
    end

    // effective size, out-of-range values clamp
    logic [SZ_W-1:0]  size_ext, eff_size;
    logic [COL_W-1:0] last_col;

    always_comb begin
        size_ext = SZ_W'(size_reg);
        if (size_ext == '0) begin
            eff_size = SZ_W'(1);
        end else if (size_ext > SZ_W'(MAX_IMAGE_SIZE)) begin
            eff_size = SZ_W'(MAX_IMAGE_SIZE);
        end else begin
            eff_size = size_ext;
        end
        last_col = COL_W'(eff_size - SZ_W'(1));
    end

    // control state
    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [1:0]          row_reg, row_next;      // 0, 1, 2 = two or more
    logic [SCORE_W-1:0]  acc_reg, acc_next;
    logic                last_reg, last_next;
    logic                flush_reg, flush_next;
    logic                do_b_reg, do_b_next;
    logic                phase_b_reg, phase_b_next;
    logic                mask_top_reg, mask_top_next;
    logic                mask_a_reg, mask_a_next;
    logic                mask_b_reg, mask_b_next;
    logic                m_valid_reg, m_valid_next;

    // payload
    logic [PIX_W-1:0]    src_reg, src_next;
    logic [PIX_W-1:0]    tgt_reg, tgt_next;
    logic [PIX_W-1:0]    held_tgt_reg, held_tgt_next;
    logic [PIX_W-1:0]    score_tgt_reg, score_tgt_next;
    logic [PIX_W-1:0]    f_reg, f_next;
    logic [SCORE_W-1:0]  m_score_reg, m_score_next;

    // line stores
    logic [2*PIX_W-1:0]  line_mem [MAX_IMAGE_SIZE];
    logic [PIX_W-1:0]    tdel_mem [MAX_IMAGE_SIZE];
    logic [2*PIX_W-1:0]  line_rd_reg;
    logic [PIX_W-1:0]    tdel_rd_reg;
    logic                mem_we;

    assign mem_we = (state_reg == S_SHIFT);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[col_reg] <= {line_rd_reg[PIX_W-1:0], src_reg};
            tdel_mem[col_reg] <= tgt_reg;
        end
        line_rd_reg <= line_mem[col_reg];
        tdel_rd_reg <= tdel_mem[col_reg];
    end

    // cell chain: cell 2 takes the new column, data moves towards cell 0
    pix_col_t            chain [4];
    logic [PSUM_W-1:0]   psum [3];
    cell_ctrl_t          cctrl [3];
    logic                emit_fire;

    always_comb begin
        if (state_reg == S_SHIFT) begin
            chain[3] = {src_reg, line_rd_reg[PIX_W-1:0], line_rd_reg[2*PIX_W-1:PIX_W]};
        end else begin
            chain[3] = '0;
        end
    end

    generate
        for (genvar j = 0; j < 3; j++) begin : g_cell
            coef_col_t coef_col;
            assign coef_col[0] = krow_top_reg[COEF_W*j +: COEF_W];
            assign coef_col[1] = krow_mid_reg[COEF_W*j +: COEF_W];
            assign coef_col[2] = krow_bot_reg[COEF_W*j +: COEF_W];

            assign cctrl[j].shift    = (state_reg == S_SHIFT) || (state_reg == S_SHIFTB);
            assign cctrl[j].clear    = emit_fire;
            assign cctrl[j].mask_top = mask_top_reg;
            assign cctrl[j].mask_col = (j == 0) ?
                                       (phase_b_reg ? mask_b_reg : mask_a_reg) : 1'b0;

            c3ss_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cctrl[j]),
                .col_in  (chain[j+1]),
                .coef    (coef_col),
                .col_out (chain[j]),
                .psum    (psum[j])
            );
        end
    endgenerate

    // filtered pixel and accumulation
    logic signed [SUM_W-1:0] total;
    logic [SUM_W-1:0]        quot;
    logic [PIX_W-1:0]        diff;
    logic [SCORE_W:0]        acc_sum;

    always_comb begin
        total = $signed(SUM_W'($signed(psum[0]))) + $signed(SUM_W'($signed(psum[1])))
              + $signed(SUM_W'($signed(psum[2])));
        quot  = SUM_W'(total >>> COEF_FRAC_BITS);
        diff  = (f_reg > score_tgt_reg) ? (f_reg - score_tgt_reg)
                                        : (score_tgt_reg - f_reg);
        acc_sum = {1'b0, acc_reg} + (SCORE_W + 1)'(diff);
    end

    assign emit_fire = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        logic col_end;
        col_end        = (col_reg >= last_col);
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        acc_next       = acc_reg;
        last_next      = last_reg;
        flush_next     = flush_reg;
        do_b_next      = do_b_reg;
        phase_b_next   = phase_b_reg;
        mask_top_next  = mask_top_reg;
        mask_a_next    = mask_a_reg;
        mask_b_next    = mask_b_reg;
        src_next       = src_reg;
        tgt_next       = tgt_reg;
        held_tgt_next  = held_tgt_reg;
        score_tgt_next = score_tgt_reg;
        f_next         = f_reg;
        m_score_next   = m_score_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    src_next   = s_source_pixel;
                    tgt_next   = s_target_pixel;
                    last_next  = s_last_pixel;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                do_b_next      = (row_reg != 2'd0) && col_end;
                mask_top_next  = (row_reg == 2'd1);
                mask_a_next    = (col_reg == COL_W'(1));
                mask_b_next    = (col_reg == '0);
                phase_b_next   = 1'b0;
                score_tgt_next = held_tgt_reg;
                held_tgt_next  = tdel_rd_reg;
                if (col_end) begin
                    col_next = '0;
                    if (row_reg != 2'd2) begin
                        row_next = row_reg + 2'd1;
                    end
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
                if ((row_reg != 2'd0) && (col_reg != '0)) begin
                    state_next = S_MUL;
                end else if ((row_reg != 2'd0) && col_end) begin
                    state_next = S_SHIFTB;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_SHIFTB: begin
                // right edge: window moves on with a zero column
                score_tgt_next = held_tgt_reg;
                phase_b_next   = 1'b1;
                state_next     = S_MUL;
            end
            S_MUL: begin
                state_next = S_SUM;
            end
            S_SUM: begin
                if (total <= 0) begin
                    f_next = '0;
                end else if (quot > SUM_W'(PIX_MAX)) begin
                    f_next = PIX_MAX;
                end else begin
                    f_next = quot[PIX_W-1:0];
                end
                state_next = S_ACC;
            end
            S_ACC: begin
                if (acc_sum > (SCORE_W + 1)'(SCORE_MAX)) begin
                    acc_next = SCORE_MAX;
                end else begin
                    acc_next = acc_sum[SCORE_W-1:0];
                end
                if (!phase_b_reg && do_b_reg) begin
                    state_next = S_SHIFTB;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                src_next = '0;
                tgt_next = '0;
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (col_reg != '0) begin
                    state_next = S_READ;            // pad the row
                end else if (!flush_reg) begin
                    flush_next = 1'b1;              // flush the final row
                    state_next = S_READ;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    m_valid_next  = 1'b1;
                    m_score_next  = acc_reg;
                    acc_next      = '0;
                    col_next      = '0;
                    row_next      = '0;
                    held_tgt_next = '0;
                    flush_next    = 1'b0;
                    last_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            acc_reg      <= '0;
            last_reg     <= 1'b0;
            flush_reg    <= 1'b0;
            do_b_reg     <= 1'b0;
            phase_b_reg  <= 1'b0;
            mask_top_reg <= 1'b0;
            mask_a_reg   <= 1'b0;
            mask_b_reg   <= 1'b0;
            held_tgt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            acc_reg      <= acc_next;
            last_reg     <= last_next;
            flush_reg    <= flush_next;
            do_b_reg     <= do_b_next;
            phase_b_reg  <= phase_b_next;
            mask_top_reg <= mask_top_next;
            mask_a_reg   <= mask_a_next;
            mask_b_reg   <= mask_b_next;
            held_tgt_reg <= held_tgt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg       <= src_next;
        tgt_reg       <= tgt_next;
        score_tgt_reg <= score_tgt_next;
        f_reg         <= f_next;
        m_score_reg   <= m_score_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_image_score = m_score_reg;

endmodule : conv3x3_sad_scorer
`default_nettype wire

[hdl/c3ss_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3ss_cell
// One window column: holds three pixels, passes them to its left neighbour
// on a shift and registers the weighted sum of its column.
// ----------------------------------------------------------------------------
module c3ss_cell (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  c3ss_pkg::cell_ctrl_t    ctrl,
    input  c3ss_pkg::pix_col_t      col_in,
    input  c3ss_pkg::coef_col_t     coef,
    output c3ss_pkg::pix_col_t      col_out,
    output logic [c3ss_pkg::PSUM_W-1:0] psum
);
    import c3ss_pkg::*;

    pix_col_t            pix_reg;
    pix_col_t            pix_next;
    logic [PSUM_W-1:0]   psum_reg;
    logic [PSUM_W-1:0]   psum_next;

    always_comb begin
        pix_next = pix_reg;
        if (ctrl.clear) begin
            pix_next = '0;
        end else if (ctrl.shift) begin
            pix_next = col_in;
        end
    end

    always_comb begin
        logic signed [PROD_W-1:0] prod [3];
        logic signed [PSUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            prod[i] = $signed({1'b0, pix_reg[i]}) * $signed(coef[i]);
            if (!(ctrl.mask_col || (i == 0 && ctrl.mask_top))) begin
                acc = acc + PSUM_W'(prod[i]);
            end
        end
        psum_next = acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg <= '0;
        end else begin
            pix_reg <= pix_next;
        end
    end

    always_ff @(posedge aclk) begin
        psum_reg <= psum_next;
    end

    assign col_out = pix_reg;
    assign psum    = psum_reg;

endmodule : c3ss_cell
`default_nettype wire

[hdl/c3ss_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3ss_checker
// Port-level checks of the scorer, bound to the top level.
// ----------------------------------------------------------------------------
module c3ss_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_valid,
    input wire                           s_ready,
    input wire                           s_last_pixel,
    input wire                           m_valid,
    input wire                           m_ready,
    input wire [c3ss_pkg::SCORE_W-1:0]   m_image_score
);
    import c3ss_pkg::*;

    // a held score word stays put
    a_score_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_image_score))
        else $error("score word changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("score valid after reset");

    // each word is worked on before the next one is taken
    a_busy_after_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // a score appears only from the flush, never alongside an input accept
    a_score_from_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("score raised outside flush");

    a_last_starts_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_pixel |=> !m_valid || !$rose(m_valid))
        else $error("score raised right after last word");

endmodule : c3ss_checker

bind conv3x3_sad_scorer c3ss_checker u_c3ss_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last_pixel  (s_last_pixel),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_image_score (m_image_score)
);
`default_nettype wire

[bench/conv3x3_sad_scorer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_sad_scorer_checker
// Watches the config port and both channels of the scorer. It keeps its own
// copy of the line stores, window and accumulator, works out the score of
// each image and compares every score word leaving on m_.
// ----------------------------------------------------------------------------
module conv3x3_sad_scorer_checker
    import c3ss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KROW_W-1:0]    cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [PIX_W-1:0]     s_source_pixel,
    input  logic [PIX_W-1:0]     s_target_pixel,
    input  logic                 s_last_pixel,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [SCORE_W-1:0]   m_image_score,
    output int                   mismatch_count,
    output int                   scores_pending
);

    localparam int MAX_N = MAX_IMAGE_SIZE_DEF;

    logic [SIZE_W-1:0]    size_reg;
    logic [KROW_W-1:0]    krow [3];
    logic [15:0]          line_st [MAX_N];
    logic [7:0]           tgt_st [MAX_N];
    logic [8:0][7:0]      win;          // row i, column j at i*3+j
    logic [7:0]           held_tgt;
    int unsigned          col_cnt;
    int unsigned          row_cnt;
    int unsigned          sad_acc;
    logic [SCORE_W-1:0]   score_q [$];

    function automatic int unsigned eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_N) return MAX_N;
        return size_reg;
    endfunction

    function automatic void add_window(logic [8:0][7:0] p, logic [7:0] t);
        longint      s;
        int unsigned f;
        int unsigned d;
        logic signed [15:0] k;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                k = krow[i][16*j +: 16];
                s += longint'(p[i*3+j]) * longint'(k);
            end
        end
        if (s <= 0) begin
            f = 0;
        end else begin
            s = s >>> COEF_FRAC_BITS_DEF;
            f = (s > 255) ? 255 : int'(s);
        end
        d = (f > t) ? f - t : t - f;
        sad_acc = (sad_acc > SCORE_MAX - d) ? SCORE_MAX : sad_acc + d;
    endfunction

    function automatic void take_pair(logic [7:0] src, logic [7:0] tgt);
        int unsigned     n;
        int unsigned     c;
        int unsigned     r;
        logic [7:0]      hi;
        logic [7:0]      lo;
        logic [7:0]      tgt_above;
        logic [8:0][7:0] p;
        n = eff_size();
        c = col_cnt;
        r = row_cnt;
        hi = line_st[c][15:8];
        lo = line_st[c][7:0];
        for (int i = 0; i < 3; i++) begin
            win[i*3+0] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = hi;
        win[5] = lo;
        win[8] = src;
        line_st[c] = {lo, src};
        tgt_above = tgt_st[c];
        tgt_st[c] = tgt;
        if (r >= 1) begin
            if (c >= 1) begin
                p = win;
                if (c == 1) begin
                    p[0] = 0; p[3] = 0; p[6] = 0;
                end
                if (r == 1) begin
                    p[0] = 0; p[1] = 0; p[2] = 0;
                end
                add_window(p, held_tgt);
            end
            // right border: centre is the pixel just taken
            if (c >= n - 1) begin
                for (int i = 0; i < 3; i++) begin
                    p[i*3+0] = (c == 0) ? 8'd0 : win[i*3+1];
                    p[i*3+1] = win[i*3+2];
                    p[i*3+2] = 0;
                end
                if (r == 1) begin
                    p[0] = 0; p[1] = 0; p[2] = 0;
                end
                add_window(p, tgt_above);
            end
        end
        held_tgt = tgt_above;
        if (c >= n - 1) begin
            col_cnt = 0;
            if (row_cnt < 1023) row_cnt++;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    function automatic void flush_row();
        int unsigned     n;
        int              cc;
        logic [15:0]     e;
        logic [8:0][7:0] p;
        n = eff_size();
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < 3; j++) begin
                cc = k - 1 + j;
                e = 0;
                if (cc >= 0 && cc < n) e = line_st[cc];
                p[j] = (row_cnt == 1) ? 8'd0 : e[15:8];
                p[3+j] = e[7:0];
                p[6+j] = 0;
            end
            add_window(p, tgt_st[k]);
        end
    endfunction

    function automatic void clear_image();
        win = '0;
        held_tgt = 0;
        col_cnt = 0;
        row_cnt = 0;
        sad_acc = 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            size_reg = 3;
            krow[0] = 0;
            krow[1] = 48'd256;
            krow[2] = 0;
            for (int i = 0; i < MAX_N; i++) begin
                line_st[i] = 0;
                tgt_st[i] = 0;
            end
            clear_image();
            score_q.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMAGE_SIZE: size_reg = cfg_data[SIZE_W-1:0];
                    CFG_KROW_TOP:   krow[0] = cfg_data;
                    CFG_KROW_MID:   krow[1] = cfg_data;
                    CFG_KROW_BOT:   krow[2] = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (score_q.size() == 0) begin
                    $error("image_score: expected none, actual %0d", m_image_score);
                    mismatch_count++;
                end else if (m_image_score !== score_q[0]) begin
                    $error("image_score: expected %0d, actual %0d",
                           score_q[0], m_image_score);
                    mismatch_count++;
                    void'(score_q.pop_front());
                end else begin
                    void'(score_q.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                take_pair(s_source_pixel, s_target_pixel);
                if (s_last_pixel) begin
                    // early last mark: pad the row with zero pairs
                    while (col_cnt != 0) take_pair(8'd0, 8'd0);
                    flush_row();
                    score_q.push_back(sad_acc[SCORE_W-1:0]);
                    clear_image();
                end
            end
        end
        scores_pending = score_q.size();
    end

endmodule

[bench/tb_conv3x3_sad_scorer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_sad_scorer
// Streams directed and random images through the scorer under changing sizes
// and kernels, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_conv3x3_sad_scorer;
    import c3ss_pkg::*;

    localparam int QUIET_LIMIT = 200000;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_SIZE;
    logic [KROW_W-1:0]    cfg_data = 0;
    logic                 s_valid = 0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_source_pixel = 0;
    logic [PIX_W-1:0]     s_target_pixel = 0;
    logic                 s_last_pixel = 0;
    logic                 m_valid;
    logic                 m_ready = 0;
    logic [SCORE_W-1:0]   m_image_score;
    int                   mismatch_count;
    int                   scores_pending;

    bit          idling = 1;
    bit          hold_req = 0;
    bit          stall_done = 0;
    int          words_sent = 0;
    int unsigned cur_n = 3;
    int          quiet = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    conv3x3_sad_scorer i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_source_pixel, .s_target_pixel, .s_last_pixel,
        .m_valid, .m_ready, .m_image_score
    );

    conv3x3_sad_scorer_checker i_checker (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_source_pixel, .s_target_pixel, .s_last_pixel,
        .m_valid, .m_ready, .m_image_score, .mismatch_count, .scores_pending
    );

    // receiver: random stalls, one long hold on request
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 0;
                repeat (3000) @(posedge aclk);
                hold_req = 0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("conv3x3_sad_scorer verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_word(logic [7:0] src, logic [7:0] tgt, logic last);
        if (idling && $urandom_range(0, 7) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1;
        s_source_pixel <= src;
        s_target_pixel <= tgt;
        s_last_pixel <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (scores_pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // block must be idle; writes all four registers
    task automatic set_config(logic [SIZE_W-1:0] sz, logic [KROW_W-1:0] top,
                              logic [KROW_W-1:0] mid, logic [KROW_W-1:0] bot);
        cfg_we <= 1;
        cfg_index <= CFG_IMAGE_SIZE; cfg_data <= KROW_W'(sz);
        @(posedge aclk);
        cfg_index <= CFG_KROW_TOP; cfg_data <= top;
        @(posedge aclk);
        cfg_index <= CFG_KROW_MID; cfg_data <= mid;
        @(posedge aclk);
        cfg_index <= CFG_KROW_BOT; cfg_data <= bot;
        @(posedge aclk);
        cfg_we <= 0;
        cur_n = (sz == 0) ? 1 : (sz > 1024) ? 1024 : sz;
    endtask

    // mode 0: random, 1: all 255 source / 0 target, 2: 0 source / 255 target
    task automatic send_image(int rows, int last_col, int mode);
        logic [7:0] src;
        logic [7:0] tgt;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cur_n; c++) begin
                src = (mode == 0) ? 8'($urandom) : (mode == 1) ? 8'hFF : 8'h00;
                tgt = (mode == 0) ? 8'($urandom) : (mode == 1) ? 8'h00 : 8'hFF;
                if (r == rows - 1 && c == last_col) begin
                    send_word(src, tgt, 1);
                    return;
                end
                send_word(src, tgt, 0);
            end
        end
    endtask

    function automatic logic [KROW_W-1:0] rand_row(bit wide);
        logic [KROW_W-1:0] v;
        for (int j = 0; j < 3; j++) begin
            v[16*j +: 16] = wide ? 16'($urandom)
                                 : 16'(int'($urandom_range(0, 1023)) - 512);
        end
        return v;
    endfunction

    initial begin
        int rows;
        int lc;
        int sz;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset config: N = 3, 1.0 on the middle row's left tap
        send_image(3, 2, 0);
        wait_idle();
        set_config(3, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
        send_image(3, 2, 1);
        wait_idle();
        set_config(3, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
        send_image(3, 2, 2);
        wait_idle();
        set_config(1, 0, 48'h0000_0100_0000, 0);
        send_image(1, 0, 1);
        wait_idle();
        set_config(0, rand_row(1), rand_row(1), rand_row(1));
        send_image(2, 0, 0);
        wait_idle();
        // taller than N, then an early last mark in the first row
        set_config(3, rand_row(0), rand_row(0), rand_row(0));
        send_image(5, 1, 0);
        send_image(1, 0, 0);
        wait_idle();
        // oversized register value acts as the largest size
        set_config(11'h7FF, rand_row(0), rand_row(0), rand_row(0));
        send_image(1, 4, 0);
        wait_idle();
        set_config(1024, rand_row(1), rand_row(1), rand_row(1));
        send_image(1, 2, 0);
        wait_idle();

        while (words_sent < 650) begin
            if (!stall_done && words_sent > 300) begin
                // long output stall: scores back up until input stalls
                stall_done = 1;
                set_config(1, rand_row(0), rand_row(0), rand_row(0));
                hold_req = 1;
                repeat (14) send_image(1, 0, 0);
                wait_idle();
            end
            if (words_sent > 560) idling = 0;
            sz = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 16)
                                              : $urandom_range(1, 8);
            set_config(SIZE_W'(sz), rand_row($urandom_range(0, 3) == 0),
                       rand_row($urandom_range(0, 3) == 0),
                       rand_row($urandom_range(0, 3) == 0));
            repeat ((sz > 8) ? 1 : $urandom_range(1, 4)) begin
                if (words_sent < 650) begin
                    case ($urandom_range(0, 5))
                        0: begin rows = cur_n + $urandom_range(1, 3); lc = cur_n - 1; end
                        1: begin rows = $urandom_range(1, cur_n);
                                 lc = $urandom_range(0, cur_n - 1); end
                        default: begin rows = cur_n; lc = cur_n - 1; end
                    endcase
                    send_image(rows, lc, 0);
                end
            end
            wait_idle();
        end

        wait_idle();
        if (mismatch_count == 0 && scores_pending == 0) begin
            $display("conv3x3_sad_scorer verification clean");
        end else begin
            $display("conv3x3_sad_scorer verification failed");
        end
        $finish;
    end

endmodule
